// ----- sv/rre_pkg.sv -----
// ----------------------------------------------------------------------------
// rre_pkg
// shared types, codes and character constants of the reply encoder
// ----------------------------------------------------------------------------
package rre_pkg;

    localparam int NUM_W       = 64;
    localparam int BIT_CNT_W   = $clog2(NUM_W);
    localparam int NUM_DIGITS  = 20;
    localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);
    localparam int TEXT_LEN    = 5;
    localparam int TEXT_IDX_W  = $clog2(TEXT_LEN);

    localparam logic [2:0] KIND_INTEGER = 3'd0;
    localparam logic [2:0] KIND_ARRAY   = 3'd1;
    localparam logic [2:0] KIND_BULK    = 3'd2;
    localparam logic [2:0] KIND_SIMPLE  = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;
    localparam logic [2:0] KIND_PAYLOAD = 3'd5;
    localparam logic [2:0] KIND_NULL    = 3'd6;
    localparam logic [2:0] KIND_OK      = 3'd7;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef struct packed {
        logic [2:0]        kind;
        logic signed [NUM_W-1:0] number;
        logic [7:0]        data_byte;
        logic              has_byte;
        logic              last_byte;
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } txd_t;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic move;
    } cell_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_MARK,
        ST_SIGN,
        ST_SKIP,
        ST_DIGIT,
        ST_CR,
        ST_LF,
        ST_TEXT,
        ST_PREFIX,
        ST_DATA
    } st_t;

    // fixed replies: null bulk and ok
    function automatic logic [7:0] text_char(input logic is_ok,
                                             input logic [TEXT_IDX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = is_ok ? CH_PLUS : CH_DOLL;
            3'd1:    c = is_ok ? CH_O    : CH_MINUS;
            3'd2:    c = is_ok ? CH_K    : CH_ONE;
            3'd3:    c = CH_CR;
            default: c = CH_LF;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/rre_bcd_cell.sv -----
// ----------------------------------------------------------------------------
// rre_bcd_cell
// one decimal digit of the shift-and-add-3 converter
// ----------------------------------------------------------------------------
module rre_bcd_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  rre_pkg::cell_ctrl_t ctrl,
    input  logic                carry_in,
    input  logic [3:0]          digit_in,
    output logic                carry_out,
    output logic [3:0]          digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    assign adj       = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign carry_out = adj[3];
    assign digit     = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = 4'd0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[2:0], carry_in};
        end
        else if (ctrl.move)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= 4'd0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

// ----- sv/rre_bcd_chain.sv -----
// ----------------------------------------------------------------------------
// rre_bcd_chain
// row of digit cells: binary shifted in at the bottom, digits read at the top
// ----------------------------------------------------------------------------
module rre_bcd_chain (
    input  logic                clk,
    input  logic                rst_n,
    input  rre_pkg::cell_ctrl_t ctrl,
    input  logic                bit_in,
    output logic [3:0]          top_digit
);

    logic [rre_pkg::NUM_DIGITS:0]   carry;
    logic [3:0] dig [rre_pkg::NUM_DIGITS+1];

    assign carry[0] = bit_in;
    assign dig[0]   = 4'd0;

    for (genvar i = 0; i < rre_pkg::NUM_DIGITS; i++)
    begin : g_cell
        rre_bcd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .carry_in  (carry[i]),
            .digit_in  (dig[i]),
            .carry_out (carry[i+1]),
            .digit     (dig[i+1])
        );
    end

    assign top_digit = dig[rre_pkg::NUM_DIGITS];

endmodule

// ----- sv/resp_reply_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// resp_reply_encoder_unit
// serializes key-value replies into a text protocol byte stream
// ----------------------------------------------------------------------------
// channel | valid     | stall     | payload
// cmd     | cmd_valid | cmd_stall | cmd (rre_pkg::cmd_t), one reply item
// txd     | txd_valid | txd_stall | txd (rre_pkg::txd_t), one output byte
//
// accepted from idle; strings then give at most four bytes, null and ok five; numbers run
// the digit chain, skip up to 19 leading zeros; one byte per cycle while txd is not stalled
// one item at a time; cmd_stall is high until its last byte is registered
// txd is a registered output; a stalled byte holds, the next waits behind it
// rst_n is asynchronous, active low; no string is open after reset
// ----------------------------------------------------------------------------
module resp_reply_encoder_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  rre_pkg::cmd_t cmd,
    output logic          txd_valid,
    input  logic          txd_stall,
    output rre_pkg::txd_t txd
);

    rre_pkg::st_t state_reg;
    rre_pkg::st_t state_next;

    logic [rre_pkg::NUM_W-1:0]      mag_reg;
    logic [rre_pkg::NUM_W-1:0]      mag_next;
    logic [rre_pkg::BIT_CNT_W-1:0]  bit_cnt_reg;
    logic [rre_pkg::BIT_CNT_W-1:0]  bit_cnt_next;
    logic [rre_pkg::DIG_CNT_W-1:0]  dig_cnt_reg;
    logic [rre_pkg::DIG_CNT_W-1:0]  dig_cnt_next;
    logic [rre_pkg::TEXT_IDX_W-1:0] text_idx_reg;
    logic [rre_pkg::TEXT_IDX_W-1:0] text_idx_next;
    logic [7:0] mark_reg;
    logic [7:0] mark_next;
    logic       neg_reg;
    logic       neg_next;
    logic       is_ok_reg;
    logic       is_ok_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic       has_reg;
    logic       has_next;
    logic       last_reg;
    logic       last_next;
    logic       string_open_reg;
    logic       string_open_next;
    logic       txd_valid_reg;
    logic       txd_valid_next;
    rre_pkg::txd_t txd_reg;
    rre_pkg::txd_t txd_next;

    logic       accept;
    logic       slot_free;
    logic       emit;
    logic       load;
    logic [7:0] emit_byte;
    logic       emit_last;
    logic       is_number;
    logic       is_text;
    logic       need_prefix;
    logic       do_skip;
    logic [3:0] top_digit;
    rre_pkg::cell_ctrl_t cell_ctrl;

    assign cmd_stall = (state_reg != rre_pkg::ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign slot_free = !txd_valid_reg || !txd_stall;
    assign load      = emit && slot_free;
    assign is_number = (cmd.kind == rre_pkg::KIND_INTEGER) ||
                       (cmd.kind == rre_pkg::KIND_ARRAY) ||
                       (cmd.kind == rre_pkg::KIND_BULK);
    assign is_text   = (cmd.kind == rre_pkg::KIND_NULL) ||
                       (cmd.kind == rre_pkg::KIND_OK);
    assign need_prefix = !string_open_reg && (cmd.kind != rre_pkg::KIND_PAYLOAD);
    assign do_skip   = (top_digit == 4'd0) && (dig_cnt_reg > 1);

    rre_bcd_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (cell_ctrl),
        .bit_in    (mag_reg[rre_pkg::NUM_W-1]),
        .top_digit (top_digit)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rre_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_number)
                    begin
                        state_next = rre_pkg::ST_CONV;
                    end
                    else if (is_text)
                    begin
                        state_next = rre_pkg::ST_TEXT;
                    end
                    else if (need_prefix)
                    begin
                        state_next = rre_pkg::ST_PREFIX;
                    end
                    else if (cmd.has_byte)
                    begin
                        state_next = rre_pkg::ST_DATA;
                    end
                    else if (cmd.last_byte)
                    begin
                        state_next = rre_pkg::ST_CR;
                    end
                end
            end
            rre_pkg::ST_CONV:
            begin
                if (bit_cnt_reg == rre_pkg::BIT_CNT_W'(rre_pkg::NUM_W - 1))
                begin
                    state_next = rre_pkg::ST_MARK;
                end
            end
            rre_pkg::ST_MARK:
            begin
                if (slot_free)
                begin
                    state_next = neg_reg ? rre_pkg::ST_SIGN : rre_pkg::ST_SKIP;
                end
            end
            rre_pkg::ST_SIGN:
            begin
                if (slot_free)
                begin
                    state_next = rre_pkg::ST_SKIP;
                end
            end
            rre_pkg::ST_SKIP:
            begin
                if (!do_skip)
                begin
                    state_next = rre_pkg::ST_DIGIT;
                end
            end
            rre_pkg::ST_DIGIT:
            begin
                if (slot_free && (dig_cnt_reg == rre_pkg::DIG_CNT_W'(1)))
                begin
                    state_next = rre_pkg::ST_CR;
                end
            end
            rre_pkg::ST_CR:
            begin
                if (slot_free)
                begin
                    state_next = rre_pkg::ST_LF;
                end
            end
            rre_pkg::ST_LF:
            begin
                if (slot_free)
                begin
                    state_next = rre_pkg::ST_IDLE;
                end
            end
            rre_pkg::ST_TEXT:
            begin
                if (slot_free &&
                    (text_idx_reg == rre_pkg::TEXT_IDX_W'(rre_pkg::TEXT_LEN - 1)))
                begin
                    state_next = rre_pkg::ST_IDLE;
                end
            end
            rre_pkg::ST_PREFIX:
            begin
                if (slot_free)
                begin
                    if (has_reg)
                    begin
                        state_next = rre_pkg::ST_DATA;
                    end
                    else if (last_reg)
                    begin
                        state_next = rre_pkg::ST_CR;
                    end
                    else
                    begin
                        state_next = rre_pkg::ST_IDLE;
                    end
                end
            end
            rre_pkg::ST_DATA:
            begin
                if (slot_free)
                begin
                    state_next = last_reg ? rre_pkg::ST_CR : rre_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rre_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        emit      = 1'b0;
        emit_byte = rre_pkg::CH_CR;
        emit_last = 1'b0;
        cell_ctrl = '0;
        case (state_reg)
            rre_pkg::ST_IDLE:
            begin
                cell_ctrl.clear = accept && is_number;
            end
            rre_pkg::ST_CONV:
            begin
                cell_ctrl.dabble = 1'b1;
            end
            rre_pkg::ST_MARK:
            begin
                emit      = 1'b1;
                emit_byte = mark_reg;
            end
            rre_pkg::ST_SIGN:
            begin
                emit      = 1'b1;
                emit_byte = rre_pkg::CH_MINUS;
            end
            rre_pkg::ST_SKIP:
            begin
                cell_ctrl.move = do_skip;
            end
            rre_pkg::ST_DIGIT:
            begin
                emit           = 1'b1;
                emit_byte      = rre_pkg::CH_ZERO + {4'd0, top_digit};
                cell_ctrl.move = slot_free;
            end
            rre_pkg::ST_CR:
            begin
                emit      = 1'b1;
                emit_byte = rre_pkg::CH_CR;
            end
            rre_pkg::ST_LF:
            begin
                emit      = 1'b1;
                emit_byte = rre_pkg::CH_LF;
                emit_last = 1'b1;
            end
            rre_pkg::ST_TEXT:
            begin
                emit      = 1'b1;
                emit_byte = rre_pkg::text_char(is_ok_reg, text_idx_reg);
                emit_last = (text_idx_reg ==
                             rre_pkg::TEXT_IDX_W'(rre_pkg::TEXT_LEN - 1));
            end
            rre_pkg::ST_PREFIX:
            begin
                emit      = 1'b1;
                emit_byte = mark_reg;
                emit_last = !has_reg && !last_reg;
            end
            rre_pkg::ST_DATA:
            begin
                emit      = 1'b1;
                emit_byte = data_reg;
                emit_last = !last_reg;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        mag_next         = mag_reg;
        bit_cnt_next     = bit_cnt_reg;
        dig_cnt_next     = dig_cnt_reg;
        text_idx_next    = text_idx_reg;
        mark_next        = mark_reg;
        neg_next         = neg_reg;
        is_ok_next       = is_ok_reg;
        data_next        = data_reg;
        has_next         = has_reg;
        last_next        = last_reg;
        string_open_next = string_open_reg;

        if (accept)
        begin
            neg_next      = cmd.number[rre_pkg::NUM_W-1];
            mag_next      = cmd.number[rre_pkg::NUM_W-1] ? (~cmd.number + 1'b1)
                                                          : cmd.number;
            bit_cnt_next  = '0;
            dig_cnt_next  = rre_pkg::DIG_CNT_W'(rre_pkg::NUM_DIGITS);
            text_idx_next = '0;
            is_ok_next    = (cmd.kind == rre_pkg::KIND_OK);
            data_next     = cmd.data_byte;
            has_next      = cmd.has_byte;
            last_next     = cmd.last_byte;
            case (cmd.kind)
                rre_pkg::KIND_INTEGER: mark_next = rre_pkg::CH_COLON;
                rre_pkg::KIND_ARRAY:   mark_next = rre_pkg::CH_STAR;
                rre_pkg::KIND_BULK:    mark_next = rre_pkg::CH_DOLL;
                rre_pkg::KIND_SIMPLE:  mark_next = rre_pkg::CH_PLUS;
                default:               mark_next = rre_pkg::CH_MINUS;
            endcase
            if (is_number || is_text)
            begin
                string_open_next = 1'b0;
            end
            else
            begin
                string_open_next = !cmd.last_byte;
            end
        end

        if (state_reg == rre_pkg::ST_CONV)
        begin
            mag_next     = {mag_reg[rre_pkg::NUM_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end

        if (cell_ctrl.move)
        begin
            dig_cnt_next = dig_cnt_reg - 1'b1;
        end

        if ((state_reg == rre_pkg::ST_TEXT) && slot_free)
        begin
            text_idx_next = text_idx_reg + 1'b1;
        end
    end

    // output register
    always_comb
    begin
        txd_valid_next = txd_valid_reg && txd_stall;
        txd_next       = txd_reg;
        if (load)
        begin
            txd_valid_next       = 1'b1;
            txd_next.out_byte    = emit_byte;
            txd_next.last_of_run = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rre_pkg::ST_IDLE;
            string_open_reg <= 1'b0;
            txd_valid_reg   <= 1'b0;
            bit_cnt_reg     <= '0;
            dig_cnt_reg     <= '0;
            text_idx_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            string_open_reg <= string_open_next;
            txd_valid_reg   <= txd_valid_next;
            bit_cnt_reg     <= bit_cnt_next;
            dig_cnt_reg     <= dig_cnt_next;
            text_idx_reg    <= text_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        mark_reg  <= mark_next;
        neg_reg   <= neg_next;
        is_ok_reg <= is_ok_next;
        data_reg  <= data_next;
        has_reg   <= has_next;
        last_reg  <= last_next;
        txd_reg   <= txd_next;
    end

    assign txd_valid = txd_valid_reg;
    assign txd       = txd_reg;

    a_digit_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rre_pkg::ST_DIGIT) |-> (top_digit <= 4'd9))
        else $error("digit chain holds a non-decimal digit");

    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rre_pkg::ST_DIGIT || state_reg == rre_pkg::ST_SKIP)
        |-> (dig_cnt_reg != '0))
        else $error("digit count ran out while emitting digits");

    a_lf_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (load && state_reg == rre_pkg::ST_LF) |=> (state_reg == rre_pkg::ST_IDLE))
        else $error("line feed transfer did not end the item");

    a_conv_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rre_pkg::ST_CONV) |-> !string_open_reg)
        else $error("string left open during number conversion");

endmodule

// ----- verif/tb_resp_reply_encoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_resp_reply_encoder_unit
// checks every serialized byte of the reply encoder against a local model of
// the reply format: a directed set of replies and string corner cases, then
// random reply sequences mixed with broken strings and raw noise, with random
// idling on both channels, a long receiver hold and a full drain pause
// ----------------------------------------------------------------------------
module tb_resp_reply_encoder_unit;

    localparam int unsigned RANDOM_ITEMS     = 235;
    localparam int unsigned TAIL_ITEMS       = 40;
    localparam int unsigned SETTLE_CYCLES    = 200;
    localparam int unsigned CYCLE_LIMIT      = 400000;
    localparam int unsigned HOLD_CYCLES      = 300;
    localparam int unsigned HOLD_AFTER_BYTES = 150;
    localparam int unsigned MAX_REPORTS      = 30;

    localparam logic signed [rre_pkg::NUM_W-1:0] NUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [rre_pkg::NUM_W-1:0] NUM_MIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        rre_pkg::cmd_t c;
        int unsigned   gap;
        bit            pause;
    } pending_cmd_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    rre_pkg::cmd_t cmd = '0;
    logic txd_valid;
    logic txd_stall = 1'b0;
    rre_pkg::txd_t txd;

    pending_cmd_t  pending[$];
    rre_pkg::txd_t reply_bytes[$];
    rre_pkg::txd_t want;
    bit           str_open;
    int unsigned  predicted_total;
    int unsigned  got_total;
    int unsigned  runs_seen;
    int unsigned  kind_count[8];
    int unsigned  errors;
    int unsigned  cycle_count;
    int unsigned  rx_burst;
    int unsigned  hold_left;
    bit           hold_done;
    bit           tail_phase;
    bit           gaps_on;
    bit           pause_next;
    int unsigned  next_pause_at;

    resp_reply_encoder_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .txd_valid (txd_valid),
        .txd_stall (txd_stall),
        .txd       (txd)
    );

    always #10 clk = ~clk;

    task automatic flag_error(input string what);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // expected bytes of one transfer, appended to reply_bytes
    function automatic void predict_reply(input rre_pkg::cmd_t c);
        rre_pkg::txd_t run[$];
        logic [63:0]   mag;
        logic [7:0]    digits[$];
        case (c.kind)
            rre_pkg::KIND_INTEGER, rre_pkg::KIND_ARRAY, rre_pkg::KIND_BULK:
            begin
                str_open = 1'b0;
                run.push_back(rre_pkg::txd_t'{
                    (c.kind == rre_pkg::KIND_INTEGER) ? rre_pkg::CH_COLON :
                    (c.kind == rre_pkg::KIND_ARRAY) ? rre_pkg::CH_STAR : rre_pkg::CH_DOLL,
                    1'b0});
                mag = c.number;
                if (c.number[rre_pkg::NUM_W-1])
                    mag = ~mag + 64'd1;
                if (mag == 64'd0)
                    digits.push_back(rre_pkg::CH_ZERO);
                while (mag != 64'd0)
                begin
                    digits.push_front(rre_pkg::CH_ZERO + 8'(mag % 64'd10));
                    mag = mag / 64'd10;
                end
                if (c.number[rre_pkg::NUM_W-1])
                    run.push_back(rre_pkg::txd_t'{rre_pkg::CH_MINUS, 1'b0});
                foreach (digits[i])
                    run.push_back(rre_pkg::txd_t'{digits[i], 1'b0});
                run.push_back(rre_pkg::txd_t'{rre_pkg::CH_CR, 1'b0});
                run.push_back(rre_pkg::txd_t'{rre_pkg::CH_LF, 1'b0});
            end
            rre_pkg::KIND_NULL:
            begin
                str_open = 1'b0;
                run.push_back(rre_pkg::txd_t'{rre_pkg::CH_DOLL, 1'b0});
                run.push_back(rre_pkg::txd_t'{rre_pkg::CH_MINUS, 1'b0});
                run.push_back(rre_pkg::txd_t'{rre_pkg::CH_ONE, 1'b0});
                run.push_back(rre_pkg::txd_t'{rre_pkg::CH_CR, 1'b0});
                run.push_back(rre_pkg::txd_t'{rre_pkg::CH_LF, 1'b0});
            end
            rre_pkg::KIND_OK:
            begin
                str_open = 1'b0;
                run.push_back(rre_pkg::txd_t'{rre_pkg::CH_PLUS, 1'b0});
                run.push_back(rre_pkg::txd_t'{rre_pkg::CH_O, 1'b0});
                run.push_back(rre_pkg::txd_t'{rre_pkg::CH_K, 1'b0});
                run.push_back(rre_pkg::txd_t'{rre_pkg::CH_CR, 1'b0});
                run.push_back(rre_pkg::txd_t'{rre_pkg::CH_LF, 1'b0});
            end
            default:
            begin
                // prefix only on the first item of a simple string or error
                if (!str_open && c.kind != rre_pkg::KIND_PAYLOAD)
                    run.push_back(rre_pkg::txd_t'{
                        (c.kind == rre_pkg::KIND_SIMPLE) ? rre_pkg::CH_PLUS
                                                         : rre_pkg::CH_MINUS,
                        1'b0});
                if (c.has_byte)
                    run.push_back(rre_pkg::txd_t'{c.data_byte, 1'b0});
                if (c.last_byte)
                begin
                    run.push_back(rre_pkg::txd_t'{rre_pkg::CH_CR, 1'b0});
                    run.push_back(rre_pkg::txd_t'{rre_pkg::CH_LF, 1'b0});
                    str_open = 1'b0;
                end
                else
                    str_open = 1'b1;
            end
        endcase
        if (run.size() != 0)
            run[run.size()-1].last_of_run = 1'b1;
        foreach (run[i])
            reply_bytes.push_back(run[i]);
        predicted_total += run.size();
    endfunction

    task automatic add_cmd(input logic [2:0] kind,
                           input logic signed [rre_pkg::NUM_W-1:0] number,
                           input logic [7:0] data, input bit has, input bit last);
        pending_cmd_t p;
        p.c.kind      = kind;
        p.c.number    = number;
        p.c.data_byte = data;
        p.c.has_byte  = has;
        p.c.last_byte = last;
        p.gap         = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        p.pause       = pause_next;
        pause_next    = 1'b0;
        pending.push_back(p);
    endtask

    function automatic logic [63:0] rand_number();
        logic [63:0] v;
        int unsigned k;
        case ($urandom_range(0, 5))
            0: v = 64'($urandom_range(0, 999));
            1: v = 64'd0 - 64'($urandom_range(1, 999));
            2, 3: v = {$urandom, $urandom};
            4:
            begin
                // around a power of ten, either sign
                v = 64'd1;
                k = $urandom_range(0, 18);
                repeat (k) v = v * 64'd10;
                v = v - 64'($urandom_range(0, 1));
                if ($urandom_range(0, 1) == 1)
                    v = ~v + 64'd1;
            end
            default: v = ($urandom_range(0, 1) == 1) ? NUM_MAX : NUM_MIN;
        endcase
        return v;
    endfunction

    // len bytes of one string kind; zero length gives one item with no byte
    task automatic add_string(input logic [2:0] kind, input int unsigned len, input bit close);
        for (int unsigned i = 0; i < len; i++)
            add_cmd(kind, rand_number(), 8'($urandom), 1'b1, close && (i == len - 1));
        if (len == 0)
            add_cmd(kind, rand_number(), 8'($urandom), 1'b0, close);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid  <= 1'b0;
            cmd        <= '0;
            tail_phase <= 1'b0;
            str_open    = 1'b0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                predict_reply(cmd);
                kind_count[cmd.kind]++;
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (pending.size() != 0 && pending[0].gap != 0)
                begin
                    pending[0].gap--;
                    cmd_valid <= 1'b0;
                end
                else if (pending.size() != 0 &&
                         !(pending[0].pause && predicted_total != got_total))
                begin
                    cmd       <= pending[0].c;
                    cmd_valid <= 1'b1;
                    void'(pending.pop_front());
                end
                else
                    cmd_valid <= 1'b0;
            end
            tail_phase <= (pending.size() < TAIL_ITEMS);
        end
    end

    // long receiver hold, once enough bytes have gone through
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && got_total >= HOLD_AFTER_BYTES)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            txd_stall <= 1'b0;
            rx_burst  <= 0;
            got_total <= 0;
        end
        else
        begin
            if (txd_valid && !txd_stall)
            begin
                got_total <= got_total + 1;
                if (reply_bytes.size() == 0)
                    flag_error($sformatf("byte %02h with no reply pending", txd.out_byte));
                else
                begin
                    want = reply_bytes.pop_front();
                    if (txd.out_byte !== want.out_byte)
                        flag_error($sformatf("byte %0d: out_byte %02h, expected %02h",
                                             got_total, txd.out_byte, want.out_byte));
                    if (txd.last_of_run !== want.last_of_run)
                        flag_error($sformatf("byte %0d: last_of_run %b, expected %b",
                                             got_total, txd.last_of_run, want.last_of_run));
                end
                if (txd.last_of_run === 1'b1)
                    runs_seen++;
            end
            if (hold_left != 0)
                txd_stall <= 1'b1;
            else if (rx_burst != 0)
            begin
                rx_burst  <= rx_burst - 1;
                txd_stall <= 1'b1;
            end
            else if (!tail_phase && !(got_total >= 400 && got_total < 550) &&
                     $urandom_range(0, 5) == 0)
            begin
                rx_burst  <= $urandom_range(0, 5);
                txd_stall <= 1'b1;
            end
            else
                txd_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, reply_bytes.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned first_random;
        int unsigned pick;
        int unsigned len;
        gaps_on = 1'b1;

        // numbers at the extremes and around digit boundaries, then payload, null, ok and simple string items
        add_cmd(rre_pkg::KIND_INTEGER, 64'sd0, 8'h00, 1'b0, 1'b0);
        add_cmd(rre_pkg::KIND_INTEGER, NUM_MAX, 8'hFF, 1'b1, 1'b1);
        add_cmd(rre_pkg::KIND_INTEGER, NUM_MIN, 8'h00, 1'b0, 1'b0);
        add_cmd(rre_pkg::KIND_INTEGER, -64'sd1, 8'h00, 1'b1, 1'b0);
        add_cmd(rre_pkg::KIND_ARRAY, 64'sd10, 8'h00, 1'b0, 1'b1);
        add_cmd(rre_pkg::KIND_BULK, -64'sd7, 8'h00, 1'b0, 1'b0);
        add_cmd(rre_pkg::KIND_BULK, 64'sd2, 8'h00, 1'b0, 1'b0);
        add_cmd(rre_pkg::KIND_PAYLOAD, 64'sd0, 8'h00, 1'b1, 1'b0);
        add_cmd(rre_pkg::KIND_PAYLOAD, 64'sd0, 8'hFF, 1'b1, 1'b1);
        add_cmd(rre_pkg::KIND_NULL, 64'sd0, 8'h00, 1'b0, 1'b0);
        add_cmd(rre_pkg::KIND_OK, NUM_MAX, 8'hFF, 1'b1, 1'b1);
        add_cmd(rre_pkg::KIND_SIMPLE, 64'sd0, 8'h68, 1'b1, 1'b0);
        add_cmd(rre_pkg::KIND_SIMPLE, 64'sd0, 8'h69, 1'b1, 1'b1);
        // empty strings
        add_cmd(rre_pkg::KIND_ERROR, 64'sd0, 8'h00, 1'b0, 1'b1);
        add_cmd(rre_pkg::KIND_SIMPLE, 64'sd0, 8'h00, 1'b0, 1'b1);
        add_cmd(rre_pkg::KIND_PAYLOAD, 64'sd0, 8'h00, 1'b0, 1'b1);
        // prefix only, then a switch of string kind, then nothing at all
        add_cmd(rre_pkg::KIND_ERROR, 64'sd0, 8'h00, 1'b0, 1'b0);
        add_cmd(rre_pkg::KIND_SIMPLE, 64'sd0, 8'h78, 1'b1, 1'b0);
        add_cmd(rre_pkg::KIND_SIMPLE, 64'sd0, 8'h00, 1'b0, 1'b0);
        // open string cut off by a number, then by a null bulk
        add_cmd(rre_pkg::KIND_INTEGER, 64'sd42, 8'h00, 1'b0, 1'b0);
        add_cmd(rre_pkg::KIND_PAYLOAD, 64'sd0, 8'h00, 1'b0, 1'b0);
        add_cmd(rre_pkg::KIND_PAYLOAD, 64'sd0, 8'h55, 1'b1, 1'b0);
        add_cmd(rre_pkg::KIND_NULL, 64'sd0, 8'h00, 1'b1, 1'b1);
        add_cmd(rre_pkg::KIND_ERROR, 64'sd0, 8'hAA, 1'b1, 1'b1);
        add_cmd(rre_pkg::KIND_ARRAY, 64'sd1000000000000000000, 8'h00, 1'b0, 1'b0);

        first_random  = pending.size();
        next_pause_at = first_random;
        while (pending.size() < first_random + RANDOM_ITEMS)
        begin
            gaps_on = ((pending.size() / 30) % 4) != 2;
            if (pending.size() >= next_pause_at)
            begin
                pause_next    = 1'b1;
                next_pause_at = next_pause_at + 90;
            end
            pick = $urandom_range(0, 99);
            if (pick < 20)
                add_cmd((pick < 10) ? rre_pkg::KIND_INTEGER : rre_pkg::KIND_ARRAY,
                        rand_number(), 8'($urandom), 1'($urandom), 1'($urandom));
            else if (pick < 35)
            begin
                len = $urandom_range(0, 6);
                add_cmd(rre_pkg::KIND_BULK, 64'(len), 8'($urandom), 1'($urandom),
                        1'($urandom));
                add_string(rre_pkg::KIND_PAYLOAD, len, 1'b1);
            end
            else if (pick < 65)
                add_string((pick < 50) ? rre_pkg::KIND_SIMPLE : rre_pkg::KIND_ERROR,
                           $urandom_range(0, 6), 1'b1);
            else if (pick < 72)
                add_cmd(rre_pkg::KIND_NULL, rand_number(), 8'($urandom), 1'($urandom),
                        1'($urandom));
            else if (pick < 79)
                add_cmd(rre_pkg::KIND_OK, rand_number(), 8'($urandom), 1'($urandom),
                        1'($urandom));
            else if (pick < 87)
                // left open: continued or cut off by whatever follows
                add_string(3'($urandom_range(rre_pkg::KIND_SIMPLE, rre_pkg::KIND_PAYLOAD)),
                           $urandom_range(0, 3), 1'b0);
            else
                add_cmd(3'($urandom), rand_number(), 8'($urandom), 1'($urandom), 1'($urandom));
        end
        for (int i = pending.size() - TAIL_ITEMS; i < pending.size(); i++)
            pending[i].gap = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || cmd_valid)
            @(posedge clk);
        while (predicted_total != got_total)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (reply_bytes.size() != 0)
            flag_error($sformatf("%0d expected bytes never arrived", reply_bytes.size()));

        $display("sent %0d integers, %0d arrays, %0d bulk headers, %0d simple, %0d error,",
                 kind_count[rre_pkg::KIND_INTEGER], kind_count[rre_pkg::KIND_ARRAY],
                 kind_count[rre_pkg::KIND_BULK], kind_count[rre_pkg::KIND_SIMPLE],
                 kind_count[rre_pkg::KIND_ERROR]);
        $display("%0d payload, %0d null, %0d ok; %0d bytes in %0d runs checked, %0d errors",
                 kind_count[rre_pkg::KIND_PAYLOAD], kind_count[rre_pkg::KIND_NULL],
                 kind_count[rre_pkg::KIND_OK], got_total, runs_seen, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
